[hw/rtl/intensity_histogram_with_peak_assert.svh]
// assertion macros shared by the histogram rtl
`ifndef INTENSITY_HISTOGRAM_WITH_PEAK_ASSERT_SVH
`define INTENSITY_HISTOGRAM_WITH_PEAK_ASSERT_SVH
`ifndef ASSERT_OFF
`define IHP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ihp assertion failed");
`define IHP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ihp assertion failed");
`else
`define IHP_ASSERT_IMP(label, clk, rst, ante, cons)
`define IHP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[hw/rtl/ihp_pkg.sv]
`timescale 1ns / 1ps
package ihp_pkg;

   localparam int COUNT_BITS_DEF = 24;
   localparam int NUM_BINS       = 256;
   localparam int BIN_W          = 8;
   localparam int OUT_COUNT_W    = 24;
   localparam int SUM_W          = 10;
   localparam int PROD_W         = 20;
   localparam int DIV3_SHIFT     = 11;

   localparam logic [SUM_W-1:0] DIV3_MUL  = 10'd683;
   localparam logic [BIN_W-1:0] MIN_RESET = 8'd255;
   localparam logic [BIN_W-1:0] MAX_RESET = 8'd0;
   localparam logic [1:0]       MODE_RESET = 2'd3;

   typedef enum logic [1:0] {
      OP_ACCUM  = 2'd0,
      OP_REPORT = 2'd1,
      OP_READ   = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      MODE_RED   = 2'd0,
      MODE_GREEN = 2'd1,
      MODE_BLUE  = 2'd2,
      MODE_MEAN  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_SCAN   = 2'd1,
      ST_DRAIN  = 2'd2,
      ST_FINISH = 2'd3
   } state_type;

   typedef struct packed {
      logic             rd_en;
      logic [BIN_W-1:0] rd_addr;
      logic             bump;
      logic             clear;
   } store_cmd_type;

   typedef struct packed {
      logic             live;
      logic [BIN_W-1:0] idx;
   } store_sample_type;

endpackage

[hw/rtl/ihp_intensity.sv]
`timescale 1ns / 1ps
module ihp_intensity
   import ihp_pkg::*;
(
   input  mode_type         mode,
   input  logic [BIN_W-1:0] chan0,
   input  logic [BIN_W-1:0] chan1,
   input  logic [BIN_W-1:0] chan2,
   output logic [BIN_W-1:0] intensity
);

   logic [SUM_W-1:0]  sum;
   logic [PROD_W-1:0] prod;
   logic [BIN_W-1:0]  mean;

   // floor(sum / 3) by reciprocal, exact for sums up to 765
   assign sum  = SUM_W'(chan0) + SUM_W'(chan1) + SUM_W'(chan2);
   assign prod = PROD_W'(sum) * PROD_W'(DIV3_MUL);
   assign mean = prod[DIV3_SHIFT +: BIN_W];

   always_comb begin
      unique case (mode)
         MODE_RED:   intensity = chan2;
         MODE_GREEN: intensity = chan1;
         MODE_BLUE:  intensity = chan0;
         MODE_MEAN:  intensity = mean;
         default:    intensity = mean;
      endcase
   end

endmodule

[hw/rtl/ihp_bin_store.sv]
`timescale 1ns / 1ps
`include "intensity_histogram_with_peak_assert.svh"
module ihp_bin_store
   import ihp_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  store_cmd_type         cmd,
   output store_sample_type      sample,
   output logic [COUNT_BITS-1:0] sample_count
);

   logic [COUNT_BITS-1:0] mem [NUM_BINS];
   logic [NUM_BINS-1:0]   valid_ff, valid_in;
   logic [COUNT_BITS-1:0] rd_q_ff;
   logic                  rd_valid_ff;
   logic                  rd_en_ff, bump_ff;
   logic [BIN_W-1:0]      addr_ff;
   logic                  lw_live_ff;
   logic [BIN_W-1:0]      lw_addr_ff;
   logic [COUNT_BITS-1:0] lw_data_ff;
   logic [COUNT_BITS-1:0] cur;
   logic                  wr_en;
   logic [COUNT_BITS-1:0] wr_data;

   // forward the write that landed on the edge the read was sampled
   always_comb begin
      if (lw_live_ff && (lw_addr_ff == addr_ff)) begin
         cur = lw_data_ff;
      end else if (rd_valid_ff) begin
         cur = rd_q_ff;
      end else begin
         cur = '0;
      end
   end

   // saturating increment
   assign wr_en   = bump_ff && !cmd.clear;
   assign wr_data = (&cur) ? cur : cur + COUNT_BITS'(1);

   assign sample.live  = rd_en_ff && !bump_ff;
   assign sample.idx   = addr_ff;
   assign sample_count = cur;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr_ff] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_q_ff     <= mem[cmd.rd_addr];
         rd_valid_ff <= valid_ff[cmd.rd_addr];
         addr_ff     <= cmd.rd_addr;
      end
      if (wr_en) begin
         lw_addr_ff <= addr_ff;
         lw_data_ff <= wr_data;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.clear) begin
         valid_in = '0;
      end else if (wr_en) begin
         valid_in[addr_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         rd_en_ff   <= 1'b0;
         bump_ff    <= 1'b0;
         lw_live_ff <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         rd_en_ff   <= cmd.rd_en;
         bump_ff    <= cmd.bump;
         lw_live_ff <= wr_en;
      end
   end

   `IHP_ASSERT_IMP(a_no_wrap, clock, reset, wr_en, wr_data != '0)
   `IHP_ASSERT_NEXT(a_clear_empties, clock, reset, cmd.clear, valid_ff == '0)
   `IHP_ASSERT_NEXT(a_write_marks, clock, reset, wr_en, valid_ff[$past(addr_ff)])

endmodule

[hw/rtl/ihp_peak_scan.sv]
`timescale 1ns / 1ps
module ihp_peak_scan
   import ihp_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
   input  logic                  clock,
   input  store_sample_type      sample,
   input  logic [COUNT_BITS-1:0] sample_count,
   input  logic [BIN_W-1:0]      target,
   output logic [BIN_W-1:0]      best_bin,
   output logic [COUNT_BITS-1:0] best_count,
   output logic [COUNT_BITS-1:0] sel_count
);

   logic [BIN_W-1:0]      best_bin_ff;
   logic [COUNT_BITS-1:0] best_count_ff, sel_count_ff;
   logic                  take;

   // strict compare keeps the lowest bin on ties; bin 0 seeds the scan
   assign take = sample.live && ((sample.idx == '0) || (sample_count > best_count_ff));

   always_ff @(posedge clock) begin
      if (take) begin
         best_bin_ff   <= sample.idx;
         best_count_ff <= sample_count;
      end
      if (sample.live && (sample.idx == target)) begin
         sel_count_ff <= sample_count;
      end
   end

   assign best_bin   = best_bin_ff;
   assign best_count = best_count_ff;
   assign sel_count  = sel_count_ff;

endmodule

[hw/rtl/intensity_histogram_with_peak.sv]
`timescale 1ns / 1ps
// accumulate and clear requests: one per cycle while no report or read holds the input
//    stalled; bin update is a read-modify-write on the bin memory with write forwarding
// report and read-bin requests: response follows a sweep of all 256 bins through the bin memory
//    read port (scan, drain and finish states), input stalled meanwhile
// reset: bins empty, min 255, max 0, channel mode 3 (mean), no response pending
`include "intensity_histogram_with_peak_assert.svh"
module intensity_histogram_with_peak
   import ihp_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_op,
   input  logic [BIN_W-1:0]       req_chan0,
   input  logic [BIN_W-1:0]       req_chan1,
   input  logic [BIN_W-1:0]       req_chan2,
   input  logic [BIN_W-1:0]       req_bin_index,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [BIN_W-1:0]       rsp_min_intensity,
   output logic [BIN_W-1:0]       rsp_max_intensity,
   output logic [BIN_W-1:0]       rsp_peak_bin,
   output logic [OUT_COUNT_W-1:0] rsp_peak_count,
   output logic [OUT_COUNT_W-1:0] rsp_bin_count,
   input  logic                   csr_wr_en,
   input  logic [1:0]             csr_wr_data
);

   state_type             state_ff, state_in;
   logic [BIN_W-1:0]      scan_idx_ff, scan_idx_in;
   logic [BIN_W-1:0]      target_ff, target_in;
   mode_type              mode_ff;
   logic [BIN_W-1:0]      min_ff, max_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [BIN_W-1:0]      rsp_min_ff, rsp_max_ff, rsp_peak_bin_ff;
   logic [OUT_COUNT_W-1:0] rsp_peak_count_ff, rsp_bin_count_ff;
   logic                  load;
   logic                  accept;
   op_type                op;
   logic [BIN_W-1:0]      intensity;
   store_cmd_type         cmd;
   store_sample_type      sample;
   logic [COUNT_BITS-1:0] sample_count;
   logic [BIN_W-1:0]      best_bin;
   logic [COUNT_BITS-1:0] best_count, sel_count;
   logic [COUNT_BITS+OUT_COUNT_W-1:0] best_ext, sel_ext;

   assign op        = op_type'(req_op);
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   ihp_intensity u_intensity (
      .mode      (mode_ff),
      .chan0     (req_chan0),
      .chan1     (req_chan1),
      .chan2     (req_chan2),
      .intensity (intensity)
   );

   always_comb begin
      cmd.bump    = accept && (op == OP_ACCUM);
      cmd.clear   = accept && (op == OP_CLEAR);
      cmd.rd_en   = cmd.bump || (state_ff == ST_SCAN);
      cmd.rd_addr = (state_ff == ST_SCAN) ? scan_idx_ff : intensity;
   end

   ihp_bin_store #(.COUNT_BITS(COUNT_BITS)) u_store (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sample       (sample),
      .sample_count (sample_count)
   );

   ihp_peak_scan #(.COUNT_BITS(COUNT_BITS)) u_scan (
      .clock        (clock),
      .sample       (sample),
      .sample_count (sample_count),
      .target       (target_ff),
      .best_bin     (best_bin),
      .best_count   (best_count),
      .sel_count    (sel_count)
   );

   assign best_ext = {{OUT_COUNT_W{1'b0}}, best_count};
   assign sel_ext  = {{OUT_COUNT_W{1'b0}}, sel_count};

   always_comb begin
      state_in    = state_ff;
      scan_idx_in = scan_idx_ff;
      target_in   = target_ff;
      load        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && ((op == OP_REPORT) || (op == OP_READ))) begin
               state_in    = ST_SCAN;
               scan_idx_in = '0;
               target_in   = req_bin_index;
            end
         end
         ST_SCAN: begin
            scan_idx_in = scan_idx_ff + BIN_W'(1);
            if (&scan_idx_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      priority if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= mode_type'(MODE_RESET);
         min_ff       <= MIN_RESET;
         max_ff       <= MAX_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            mode_ff <= mode_type'(csr_wr_data);
         end
         if (cmd.clear) begin
            min_ff <= MIN_RESET;
            max_ff <= MAX_RESET;
         end else if (cmd.bump) begin
            if (intensity < min_ff) begin
               min_ff <= intensity;
            end
            if (intensity > max_ff) begin
               max_ff <= intensity;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_idx_in;
      target_ff   <= target_in;
      if (load) begin
         rsp_min_ff        <= min_ff;
         rsp_max_ff        <= max_ff;
         rsp_peak_bin_ff   <= best_bin;
         rsp_peak_count_ff <= best_ext[OUT_COUNT_W-1:0];
         rsp_bin_count_ff  <= sel_ext[OUT_COUNT_W-1:0];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_min_intensity = rsp_min_ff;
   assign rsp_max_intensity = rsp_max_ff;
   assign rsp_peak_bin      = rsp_peak_bin_ff;
   assign rsp_peak_count    = rsp_peak_count_ff;
   assign rsp_bin_count     = rsp_bin_count_ff;

   `IHP_ASSERT_IMP(a_min_max_order, clock, reset, 1'b1,
      (min_ff <= max_ff) || ((min_ff == MIN_RESET) && (max_ff == MAX_RESET)))
   `IHP_ASSERT_IMP(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff) == ST_FINISH)
   `IHP_ASSERT_IMP(a_sample_in_scan, clock, reset, sample.live,
      (state_ff == ST_SCAN) || (state_ff == ST_DRAIN))

endmodule

[dv/tb_intensity_histogram_with_peak.sv]
`timescale 1ns / 1ps
module tb_intensity_histogram_with_peak;
   import ihp_pkg::*;

   localparam int COUNT_W         = COUNT_BITS_DEF;
   localparam int SETTLE_CYCLES   = 8;
   localparam int TAIL_CYCLES     = 300;
   localparam int ITEMS_PER_PHASE = 234;
   localparam int TIMEOUT_NS      = 20_000_000;
   localparam int NUM_DIRECTED    = 24;

   typedef struct packed {
      logic [BIN_W-1:0]       min_i;
      logic [BIN_W-1:0]       max_i;
      logic [BIN_W-1:0]       peak_b;
      logic [OUT_COUNT_W-1:0] peak_c;
      logic [OUT_COUNT_W-1:0] bin_c;
   } hist_stats_type;

   typedef enum logic {
      ROW_REQ = 1'b0,
      ROW_CFG = 1'b1
   } row_kind_type;

   typedef struct {
      row_kind_type     kind;
      mode_type         mode;
      op_type           op;
      logic [BIN_W-1:0] c0;
      logic [BIN_W-1:0] c1;
      logic [BIN_W-1:0] c2;
      logic [BIN_W-1:0] idx;
      logic             pinned;
      hist_stats_type   lit;
   } dir_row_type;

   localparam hist_stats_type NO_STATS    = '0;
   localparam hist_stats_type RESET_STATS = '{MIN_RESET, MAX_RESET, 8'd0, 24'd0, 24'd0};

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [1:0]             req_op;
   logic [BIN_W-1:0]       req_chan0;
   logic [BIN_W-1:0]       req_chan1;
   logic [BIN_W-1:0]       req_chan2;
   logic [BIN_W-1:0]       req_bin_index;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [BIN_W-1:0]       rsp_min_intensity;
   logic [BIN_W-1:0]       rsp_max_intensity;
   logic [BIN_W-1:0]       rsp_peak_bin;
   logic [OUT_COUNT_W-1:0] rsp_peak_count;
   logic [OUT_COUNT_W-1:0] rsp_bin_count;
   logic                   csr_wr_en;
   logic [1:0]             csr_wr_data;

   // literal expectation travels with the request it belongs to
   logic           pin_use;
   hist_stats_type pin_stats;

   logic [COUNT_W-1:0] hist_bins [NUM_BINS];
   logic [BIN_W-1:0]   hist_min;
   logic [BIN_W-1:0]   hist_max;
   mode_type           hist_mode;
   hist_stats_type     pending_stats [$];

   int fail_count;
   int send_idle_pct;
   int recv_idle_pct;

   dir_row_type directed_rows [NUM_DIRECTED] = '{
      '{ROW_REQ, MODE_MEAN,  OP_READ,   8'h00, 8'h00, 8'h00, 8'h00, 1'b1, RESET_STATS},
      '{ROW_REQ, MODE_MEAN,  OP_REPORT, 8'h12, 8'h34, 8'h56, 8'hff, 1'b1, RESET_STATS},
      '{ROW_REQ, MODE_MEAN,  OP_ACCUM,  8'hff, 8'hff, 8'hff, 8'h00, 1'b0, NO_STATS},
      '{ROW_REQ, MODE_MEAN,  OP_READ,   8'h00, 8'h00, 8'h00, 8'hff, 1'b1,
        '{8'd255, 8'd255, 8'd255, 24'd1, 24'd1}},
      '{ROW_REQ, MODE_MEAN,  OP_ACCUM,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0, NO_STATS},
      '{ROW_REQ, MODE_MEAN,  OP_REPORT, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1,
        '{8'd0, 8'd255, 8'd0, 24'd1, 24'd1}},
      '{ROW_REQ, MODE_MEAN,  OP_ACCUM,  8'hfe, 8'hff, 8'hff, 8'h00, 1'b0, NO_STATS},
      '{ROW_REQ, MODE_MEAN,  OP_ACCUM,  8'h01, 8'h00, 8'h00, 8'h00, 1'b0, NO_STATS},
      '{ROW_REQ, MODE_MEAN,  OP_ACCUM,  8'h00, 8'h02, 8'h00, 8'h00, 1'b0, NO_STATS},
      '{ROW_REQ, MODE_MEAN,  OP_READ,   8'h00, 8'h00, 8'h00, 8'hfe, 1'b0, NO_STATS},
      '{ROW_CFG, MODE_RED,   OP_ACCUM,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0, NO_STATS},
      '{ROW_REQ, MODE_MEAN,  OP_ACCUM,  8'h11, 8'h22, 8'haa, 8'h00, 1'b0, NO_STATS},
      '{ROW_CFG, MODE_GREEN, OP_ACCUM,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0, NO_STATS},
      '{ROW_REQ, MODE_MEAN,  OP_ACCUM,  8'h55, 8'haa, 8'h0f, 8'h00, 1'b0, NO_STATS},
      '{ROW_CFG, MODE_BLUE,  OP_ACCUM,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0, NO_STATS},
      '{ROW_REQ, MODE_MEAN,  OP_ACCUM,  8'h5a, 8'h00, 8'hff, 8'h00, 1'b0, NO_STATS},
      '{ROW_REQ, MODE_MEAN,  OP_REPORT, 8'h00, 8'h00, 8'h00, 8'haa, 1'b0, NO_STATS},
      '{ROW_REQ, MODE_MEAN,  OP_CLEAR,  8'hff, 8'hff, 8'hff, 8'hff, 1'b0, NO_STATS},
      '{ROW_REQ, MODE_MEAN,  OP_READ,   8'h00, 8'h00, 8'h00, 8'h00, 1'b1, RESET_STATS},
      '{ROW_REQ, MODE_MEAN,  OP_ACCUM,  8'h07, 8'hc8, 8'h09, 8'h00, 1'b0, NO_STATS},
      '{ROW_REQ, MODE_MEAN,  OP_REPORT, 8'h00, 8'h00, 8'h00, 8'h07, 1'b0, NO_STATS},
      '{ROW_CFG, MODE_MEAN,  OP_ACCUM,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0, NO_STATS},
      '{ROW_REQ, MODE_MEAN,  OP_ACCUM,  8'h80, 8'h7f, 8'h01, 8'h00, 1'b0, NO_STATS},
      '{ROW_REQ, MODE_MEAN,  OP_READ,   8'h00, 8'h00, 8'h00, 8'h55, 1'b0, NO_STATS}
   };

   intensity_histogram_with_peak dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_chan0         (req_chan0),
      .req_chan1         (req_chan1),
      .req_chan2         (req_chan2),
      .req_bin_index     (req_bin_index),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_min_intensity (rsp_min_intensity),
      .rsp_max_intensity (rsp_max_intensity),
      .rsp_peak_bin      (rsp_peak_bin),
      .rsp_peak_count    (rsp_peak_count),
      .rsp_bin_count     (rsp_bin_count),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Regression FAIL");
      $finish;
   end

   function automatic logic [BIN_W-1:0] pixel_intensity(input mode_type m,
         input logic [BIN_W-1:0] c0, input logic [BIN_W-1:0] c1,
         input logic [BIN_W-1:0] c2);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(c0) + SUM_W'(c1) + SUM_W'(c2);
      case (m)
         MODE_RED:   return c2;
         MODE_GREEN: return c1;
         MODE_BLUE:  return c0;
         default:    return BIN_W'(sum / 3);
      endcase
   endfunction

   function automatic hist_stats_type read_stats(input logic [BIN_W-1:0] idx);
      hist_stats_type     s;
      logic [COUNT_W-1:0] best;
      s.min_i  = hist_min;
      s.max_i  = hist_max;
      s.peak_b = '0;
      best     = hist_bins[0];
      for (int b = 1; b < NUM_BINS; b++) begin
         if (hist_bins[b] > best) begin
            best     = hist_bins[b];
            s.peak_b = BIN_W'(b);
         end
      end
      s.peak_c = OUT_COUNT_W'(best);
      s.bin_c  = OUT_COUNT_W'(hist_bins[idx]);
      return s;
   endfunction

   task automatic clear_hist();
      foreach (hist_bins[b]) hist_bins[b] = '0;
      hist_min = MIN_RESET;
      hist_max = MAX_RESET;
   endtask

   task automatic check_field(input string name, input int unsigned want,
         input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      hist_stats_type   want;
      logic [BIN_W-1:0] v;
      if (reset) begin
         clear_hist();
         hist_mode = MODE_MEAN;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_stats.size() == 0) begin
               $error("response with no request waiting");
               fail_count++;
            end else begin
               want = pending_stats.pop_front();
               check_field("min_intensity", want.min_i, rsp_min_intensity);
               check_field("max_intensity", want.max_i, rsp_max_intensity);
               check_field("peak_bin", want.peak_b, rsp_peak_bin);
               check_field("peak_count", want.peak_c, rsp_peak_count);
               check_field("bin_count", want.bin_c, rsp_bin_count);
            end
         end
         if (csr_wr_en) hist_mode = mode_type'(csr_wr_data);
         if (req_valid && !req_stall) begin
            case (op_type'(req_op))
               OP_ACCUM: begin
                  v = pixel_intensity(hist_mode, req_chan0, req_chan1, req_chan2);
                  if (hist_bins[v] != {COUNT_W{1'b1}}) hist_bins[v] = hist_bins[v] + 1'b1;
                  if (v < hist_min) hist_min = v;
                  if (v > hist_max) hist_max = v;
               end
               OP_CLEAR: clear_hist();
               default: pending_stats.insert(pending_stats.size(),
                                             pin_use ? pin_stats : read_stats(req_bin_index));
            endcase
         end
      end
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   task automatic send_request(input op_type op, input logic [BIN_W-1:0] c0,
         input logic [BIN_W-1:0] c1, input logic [BIN_W-1:0] c2,
         input logic [BIN_W-1:0] idx, input logic pinned, input hist_stats_type lit);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_op        <= op;
      req_chan0     <= c0;
      req_chan1     <= c1;
      req_chan2     <= c2;
      req_bin_index <= idx;
      pin_use       <= pinned;
      pin_stats     <= lit;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_stats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input mode_type m);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      op_type           op;
      logic [BIN_W-1:0] hot;
      logic [BIN_W-1:0] c0, c1, c2, idx;
      int               r;
      int               n;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_op         = OP_ACCUM;
      req_chan0      = '0;
      req_chan1      = '0;
      req_chan2      = '0;
      req_bin_index  = '0;
      rsp_stall      = 1'b0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = MODE_RESET;
      pin_use        = 1'b0;
      pin_stats      = NO_STATS;
      fail_count     = 0;
      send_idle_pct  = 0;
      recv_idle_pct  = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CFG) begin
            write_mode(directed_rows[i].mode);
         end else begin
            send_request(directed_rows[i].op, directed_rows[i].c0, directed_rows[i].c1,
                         directed_rows[i].c2, directed_rows[i].idx,
                         directed_rows[i].pinned, directed_rows[i].lit);
         end
      end

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 19;
               recv_idle_pct = 48;
            end
            1: begin
               send_idle_pct = 48;
               recv_idle_pct = 19;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         write_mode(mode_type'($urandom_range(3)));
         hot = BIN_W'($urandom);
         n = 0;
         while (n < ITEMS_PER_PHASE) begin
            r = $urandom_range(999);
            if (r < 20) op = OP_CLEAR;
            else if (r < 90) op = OP_REPORT;
            else if (r < 160) op = OP_READ;
            else op = OP_ACCUM;
            // half the pixels cluster so that peaks and ties form
            if ($urandom_range(1) == 1) begin
               c0 = BIN_W'($urandom);
               c1 = BIN_W'($urandom);
               c2 = BIN_W'($urandom);
            end else begin
               c0 = hot + BIN_W'($urandom_range(3));
               c1 = hot + BIN_W'($urandom_range(3));
               c2 = hot + BIN_W'($urandom_range(3));
            end
            idx = ($urandom_range(1) == 1) ? BIN_W'($urandom) : hot + BIN_W'($urandom_range(3));
            send_request(op, c0, c1, c2, idx, 1'b0, NO_STATS);
            n++;
            if ($urandom_range(199) == 0) wait_idle();
         end
      end

      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_stats.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
